### sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the Q24.8 fixed-point ALU
// Word layout, mode codes, divider widths and the per-stage transaction record.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;
  localparam int FRAC_BITS = 8;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 4;
  // Divider: numerator 2*|a|*2^F + |b|, denominator 2*|b|
  localparam int NUM_W     = WORD_W + FRAC_BITS + 2;
  localparam int DEN_W     = WORD_W + 1;
  localparam int QB        = WORD_W + 1;       // quotient bits resolved in the cell row
  localparam int HI_W      = NUM_W - QB;       // top numerator bits preloaded as remainder
  localparam int REM_W     = DEN_W + 1;
  localparam int PROD_W    = 2 * WORD_W;

  localparam logic [MODE_W-1:0] MODE_ADD  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUB  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MUL  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DIV  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_MIN  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_MAX  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_INC  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_DEC  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_TOI  = 4'd8;
  localparam logic [MODE_W-1:0] MODE_FROMI = 4'd9;

  localparam logic [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              lt;
    logic              eq;
    logic              gt;
    logic [WORD_W-1:0] res;    // result of the modes other than mul and div
    logic              ovf;
    logic              neg;    // sign of mul/div result
    logic              dbz;
    logic              dovf;   // quotient exceeds the cell row
    logic [PROD_W-1:0] prod;   // |a|*|b|
    logic [REM_W-1:0]  rem;
    logic [QB-1:0]     num;    // numerator bits still to shift in
    logic [DEN_W-1:0]  den;
    logic [QB-1:0]     quo;
  } fpa_cell_t;
endpackage
`default_nettype wire

### sv/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front: operand decode stage
// Results of the modes other than mul and div, flags, magnitude product and divider setup, registered.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic [fpa_pkg::MODE_W-1:0] mode,
  input  wire logic [fpa_pkg::WORD_W-1:0] op_a,
  input  wire logic [fpa_pkg::WORD_W-1:0] op_b,
  output logic                           out_v_r,
  output fpa_pkg::fpa_cell_t             out_d_r
);
  import fpa_pkg::*;

  function automatic logic [WORD_W:0] sat_sum(input logic [WORD_W:0] v);
    if (v[WORD_W] != v[WORD_W-1]) return {1'b1, (v[WORD_W] ? W_MIN : W_MAX)};
    return {1'b0, v[WORD_W-1:0]};
  endfunction

  logic signed [WORD_W-1:0] sa, sb;
  logic [WORD_W:0] ea, eb;
  logic [WORD_W-1:0] mag_a, mag_b;
  logic [WORD_W+FRAC_BITS-1:0] fi;
  logic fi_fit;
  logic [NUM_W-1:0] numer;
  logic [DEN_W-1:0] den;
  logic [WORD_W:0] r_sel;
  fpa_cell_t d_nxt;

  always_comb begin
    sa    = $signed(op_a);
    sb    = $signed(op_b);
    ea    = {op_a[WORD_W-1], op_a};
    eb    = {op_b[WORD_W-1], op_b};
    mag_a = op_a[WORD_W-1] ? (~op_a + 1'b1) : op_a;
    mag_b = op_b[WORD_W-1] ? (~op_b + 1'b1) : op_b;
    fi    = {op_a, {FRAC_BITS{1'b0}}};
    fi_fit = (&fi[WORD_W+FRAC_BITS-1:WORD_W-1]) | ~(|fi[WORD_W+FRAC_BITS-1:WORD_W-1]);
    numer = {1'b0, mag_a, {(FRAC_BITS+1){1'b0}}} + {{(NUM_W-WORD_W){1'b0}}, mag_b};
    den   = {mag_b, 1'b0};
    unique case (mode)
      MODE_ADD:   r_sel = sat_sum(ea + eb);
      MODE_SUB:   r_sel = sat_sum(ea - eb);
      MODE_INC:   r_sel = sat_sum(ea + 1'b1);
      MODE_DEC:   r_sel = sat_sum(ea - 1'b1);
      MODE_MIN:   r_sel = {1'b0, (sa < sb) ? op_a : op_b};
      MODE_MAX:   r_sel = {1'b0, (sa > sb) ? op_a : op_b};
      MODE_TOI:   r_sel = {1'b0, WORD_W'(sa >>> FRAC_BITS)};
      MODE_FROMI: r_sel = fi_fit ? {1'b0, fi[WORD_W-1:0]}
                                 : {1'b1, (op_a[WORD_W-1] ? W_MIN : W_MAX)};
      default:    r_sel = '0;
    endcase
    d_nxt.mode = mode;
    d_nxt.lt   = sa < sb;
    d_nxt.eq   = op_a == op_b;
    d_nxt.gt   = sa > sb;
    d_nxt.res  = r_sel[WORD_W-1:0];
    d_nxt.ovf  = r_sel[WORD_W];
    d_nxt.neg  = op_a[WORD_W-1] ^ op_b[WORD_W-1];
    d_nxt.dbz  = (op_b == '0);
    d_nxt.dovf = {{(DEN_W-HI_W){1'b0}}, numer[NUM_W-1:QB]} >= den;
    d_nxt.prod = PROD_W'(mag_a) * PROD_W'(mag_b);
    d_nxt.rem  = {{(REM_W-HI_W){1'b0}}, numer[NUM_W-1:QB]};
    d_nxt.num  = numer[QB-1:0];
    d_nxt.den  = den;
    d_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= d_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/fpa_div_cell.sv
// ----------------------------------------------------------------------------
// fpa_div_cell: one restoring-division step
// Resolves one quotient bit and hands the transaction to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_div_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_v,
  input  fpa_pkg::fpa_cell_t      in_d,
  output logic                    out_v_r,
  output fpa_pkg::fpa_cell_t      out_d_r
);
  import fpa_pkg::*;

  logic [REM_W-1:0] trial;
  logic             qbit;
  fpa_cell_t        d_nxt;

  always_comb begin
    trial = {in_d.rem[REM_W-2:0], in_d.num[QB-1]};
    qbit  = trial >= {1'b0, in_d.den};
    d_nxt = in_d;
    d_nxt.rem = qbit ? (trial - {1'b0, in_d.den}) : trial;
    d_nxt.num = {in_d.num[QB-2:0], 1'b0};
    d_nxt.quo = {in_d.quo[QB-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d_r <= d_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back: result stage
// Rounds and saturates mul/div, selects the result and holds the output.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_v,
  input  fpa_pkg::fpa_cell_t              in_d,
  output logic                            out_valid_r,
  output logic [fpa_pkg::WORD_W-1:0]      result_r,
  output logic                            lt_r,
  output logic                            eq_r,
  output logic                            gt_r,
  output logic                            ovf_r,
  output logic                            dbz_r
);
  import fpa_pkg::*;

  logic [PROD_W-1:0] rnd;
  logic [PROD_W-FRAC_BITS-1:0] mq;
  logic [PROD_W-FRAC_BITS-1:0] mag;
  logic big;
  logic [WORD_W-1:0] res_nxt;
  logic ovf_nxt;

  always_comb begin
    rnd = in_d.prod + PROD_W'(1 << (FRAC_BITS-1));
    mq  = rnd[PROD_W-1:FRAC_BITS];
    mag = (in_d.mode == MODE_MUL) ? mq : (PROD_W-FRAC_BITS)'(in_d.quo);
    // positive limit 2^(W-1)-1, negative limit 2^(W-1)
    big = in_d.neg ? (mag > (PROD_W-FRAC_BITS)'(W_MIN))
                   : (mag > (PROD_W-FRAC_BITS)'(W_MAX));
    if (in_d.mode == MODE_DIV) big = big | in_d.dovf;
    res_nxt = in_d.res;
    ovf_nxt = in_d.ovf;
    if (in_d.mode == MODE_MUL || (in_d.mode == MODE_DIV && !in_d.dbz)) begin
      ovf_nxt = big;
      if (big) res_nxt = in_d.neg ? W_MIN : W_MAX;
      else res_nxt = in_d.neg ? (~mag[WORD_W-1:0] + 1'b1) : mag[WORD_W-1:0];
    end else if (in_d.mode == MODE_DIV) begin
      ovf_nxt = 1'b0;
      res_nxt = (in_d.lt && !in_d.neg) || (in_d.neg && in_d.lt) ? W_MIN : W_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= res_nxt;
      lt_r     <= in_d.lt;
      eq_r     <= in_d.eq;
      gt_r     <= in_d.gt;
      ovf_r    <= ovf_nxt;
      dbz_r    <= (in_d.mode == MODE_DIV) && in_d.dbz;
    end
  end
endmodule
`default_nettype wire

### sv/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point ALU
// Add, sub, mul, div, min, max, inc, dec and integer conversions with flags.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction per cycle while the output is not stalled,
// through the decode stage, a row of 33 restoring-divider cells producing one
// quotient bit each, and the output register. All modes travel the same row,
// so results leave in order. A stalled output freezes the whole row.
`default_nettype none
module fixed_point_q24_8_alu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [fpa_pkg::MODE_W-1:0] in_mode,
  input  wire logic [fpa_pkg::WORD_W-1:0] in_operand_a,
  input  wire logic [fpa_pkg::WORD_W-1:0] in_operand_b,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [fpa_pkg::WORD_W-1:0]      out_result,
  output logic                            out_a_less,
  output logic                            out_a_equal,
  output logic                            out_a_greater,
  output logic                            out_overflow,
  output logic                            out_divide_by_zero
);
  import fpa_pkg::*;

  logic      en;
  logic      st_v [QB+1];
  fpa_cell_t st_d [QB+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  fpa_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_valid),
    .mode(in_mode), .op_a(in_operand_a), .op_b(in_operand_b),
    .out_v_r(st_v[0]), .out_d_r(st_d[0])
  );

  for (genvar i = 0; i < QB; i++) begin : g_cell
    fpa_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_v(st_v[i]), .in_d(st_d[i]),
      .out_v_r(st_v[i+1]), .out_d_r(st_d[i+1])
    );
  end

  fpa_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_v(st_v[QB]), .in_d(st_d[QB]),
    .out_valid_r(out_valid), .result_r(out_result),
    .lt_r(out_a_less), .eq_r(out_a_equal), .gt_r(out_a_greater),
    .ovf_r(out_overflow), .dbz_r(out_divide_by_zero)
  );

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_a_less, out_a_equal, out_a_greater}))
    else $error("comparison flags not one-hot");
  a_dbz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> !out_overflow && out_a_equal == 1'b0
      || out_valid && out_divide_by_zero && !out_overflow)
    else $error("divide by zero with overflow");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(st_v[QB]) && $stable(st_v[0]))
    else $error("pipeline moved during stall");
endmodule
`default_nettype wire
